[rtl/mnpc_pkg.sv]
// Shared types and constants for the mixed numeric predicate compare block.
package mnpc_pkg;

    typedef enum logic [1:0] {
        KIND_SINT  = 2'd0,
        KIND_UINT  = 2'd1,
        KIND_FLOAT = 2'd2,
        KIND_ALT   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REL_EQ = 3'd0,
        REL_NE = 3'd1,
        REL_LT = 3'd2,
        REL_LE = 3'd3,
        REL_GT = 3'd4,
        REL_GE = 3'd5,
        REL_X6 = 3'd6,
        REL_X7 = 3'd7
    } t_rel;

    localparam logic [1:0] CFG_RELATION = 2'd0;
    localparam logic [1:0] CFG_EXP_KIND = 2'd1;
    localparam logic [1:0] CFG_EXP_VAL  = 2'd2;

    typedef struct packed {
        logic [1:0]  actual_kind;
        logic [63:0] actual_value;
    } t_in;

    typedef struct packed {
        logic satisfied;
        logic status;
    } t_out;

    // Operand mapped to a common form: key = 2^64 + integer part, as 66-bit
    // two's complement (floor for floats, clamped), plus a fraction flag.
    // Floats also carry a monotonic 64-bit key for float-to-float order.
    typedef struct packed {
        logic        nonfinite;
        logic [65:0] key;
        logic        frac;
        logic        is_float;
        logic [63:0] fkey;
    } t_norm;

    typedef struct packed {
        logic less;
        logic equal;
        logic unord;
    } t_ord;

endpackage

[rtl/mnpc_norm.sv]
// Operand normalizer: maps an int64, uint64 or binary64 pattern to a floor key.
module mnpc_norm (
    input  logic [1:0]          i_kind,
    input  logic [63:0]         i_value,
    output mnpc_pkg::t_norm     o_norm
);
    import mnpc_pkg::*;

    logic        w_sign;
    logic [10:0] w_exp;
    logic [52:0] w_mant;
    logic [64:0] w_mag;
    logic        w_frac;
    logic [63:0] w_fracmask;
    logic [11:0] w_sh;

    assign w_sign = i_value[63];
    assign w_exp  = i_value[62:52];
    assign w_mant = {1'b1, i_value[51:0]};

    always_comb begin
        w_mag      = '0;
        w_frac     = 1'b0;
        w_fracmask = '0;
        w_sh       = 12'd0;
        if (w_exp == 11'd0) begin
            // zero or subnormal: magnitude below one
            w_frac = (i_value[51:0] != 52'd0);
        end else if (w_exp < 11'd1023) begin
            w_frac = 1'b1;
        end else if (w_exp >= 11'd1087) begin
            // at or beyond 2^64: clamp to 2^64
            w_mag = 65'h1_0000_0000_0000_0000;
        end else if (w_exp >= 11'd1075) begin
            w_sh  = {1'b0, w_exp} - 12'd1075;
            w_mag = {12'd0, w_mant} << w_sh[5:0];
        end else begin
            w_sh       = 12'd1075 - {1'b0, w_exp};
            w_mag      = {12'd0, w_mant >> w_sh[5:0]};
            w_fracmask = (64'd1 << w_sh[5:0]) - 64'd1;
            w_frac     = (({11'd0, w_mant} & w_fracmask) != 64'd0);
        end
    end

    always_comb begin
        o_norm.nonfinite = 1'b0;
        o_norm.frac      = 1'b0;
        o_norm.is_float  = 1'b0;
        o_norm.fkey      = '0;
        case (i_kind)
            KIND_SINT: o_norm.key = {2'b00, ~i_value[63], i_value[62:0]} +
                                    66'h0_8000_0000_0000_0000;
            KIND_UINT: o_norm.key = {2'b01, i_value};
            default: begin
                o_norm.nonfinite = (w_exp == 11'h7FF);
                o_norm.is_float  = 1'b1;
                // sign-magnitude to monotonic order, both zeros folded together
                if (i_value[62:0] == 63'd0) begin
                    o_norm.fkey = 64'h8000_0000_0000_0000;
                end else if (w_sign) begin
                    o_norm.fkey = ~i_value;
                end else begin
                    o_norm.fkey = {1'b1, i_value[62:0]};
                end
                if (!w_sign) begin
                    o_norm.key  = {1'b0, w_mag} + 66'h1_0000_0000_0000_0000;
                    o_norm.frac = w_frac;
                end else begin
                    // floor of a negative value: -(mag + frac)
                    o_norm.key  = 66'h1_0000_0000_0000_0000 - {1'b0, w_mag} -
                                  {65'd0, w_frac};
                    o_norm.frac = w_frac;
                end
            end
        endcase
    end
endmodule

[rtl/mnpc_cmp.sv]
// Key comparator: orders two normalized operands.
module mnpc_cmp (
    input  mnpc_pkg::t_norm i_a,
    input  mnpc_pkg::t_norm i_b,
    output mnpc_pkg::t_ord  o_ord
);
    import mnpc_pkg::*;

    logic w_kl, w_ke;
    logic w_fl, w_fe;
    assign w_kl = i_a.key < i_b.key;
    assign w_ke = i_a.key == i_b.key;
    assign w_fl = i_a.fkey < i_b.fkey;
    assign w_fe = i_a.fkey == i_b.fkey;

    always_comb begin
        o_ord.unord = i_a.nonfinite | i_b.nonfinite;
        if (i_a.is_float && i_b.is_float) begin
            // two floats: order on the full value, not the clamped floor
            o_ord.equal = w_fe;
            o_ord.less  = w_fl;
        end else begin
            o_ord.equal = w_ke && (i_a.frac == i_b.frac);
            o_ord.less  = w_kl || (w_ke && !i_a.frac && i_b.frac);
        end
    end
endmodule

[rtl/mixed_numeric_predicate_compare.sv]
// Top level: exact compare of a tagged number against a configured number.
//   channel  | direction | handshake
//   input    | in        | i_valid / o_stall, payload i_data
//   output   | out       | o_valid / i_stall, payload o_data
// Three register stages: normalize, order, relation.
// One transaction per cycle when the output side does not stall.
// A stall holds every stage; a bubble in a stage is filled while stalled.
// Synchronous active-low reset clears valid bits and configuration.
module mixed_numeric_predicate_compare (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  mnpc_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output mnpc_pkg::t_out   o_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [63:0]      i_cfg_data
);
    import mnpc_pkg::*;

    logic [2:0]  r_rel;
    logic [1:0]  r_ekind;
    logic [63:0] r_eval;

    t_norm w_na, w_nb, r_na, r_nb;
    t_ord  w_ord, r_ord;
    t_out  r_out, n_out;
    logic  r_v1, r_v2, r_v3;
    logic  w_en1, w_en2, w_en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel   <= '0;
            r_ekind <= '0;
            r_eval  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_RELATION: r_rel   <= i_cfg_data[2:0];
                CFG_EXP_KIND: r_ekind <= i_cfg_data[1:0];
                CFG_EXP_VAL:  r_eval  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mnpc_norm u_na (.i_kind(i_data.actual_kind), .i_value(i_data.actual_value),
                    .o_norm(w_na));
    mnpc_norm u_nb (.i_kind(r_ekind), .i_value(r_eval), .o_norm(w_nb));
    mnpc_cmp  u_cmp (.i_a(r_na), .i_b(r_nb), .o_ord(w_ord));

    assign w_en3   = !r_v3 || !i_stall;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;

    always_comb begin
        n_out.status    = r_ord.unord;
        n_out.satisfied = 1'b0;
        if (!r_ord.unord) begin
            case (t_rel'(r_rel))
                REL_EQ: n_out.satisfied = r_ord.equal;
                REL_NE: n_out.satisfied = !r_ord.equal;
                REL_LT: n_out.satisfied = r_ord.less;
                REL_LE: n_out.satisfied = r_ord.less || r_ord.equal;
                REL_GT: n_out.satisfied = !r_ord.less && !r_ord.equal;
                REL_GE: n_out.satisfied = !r_ord.less;
                default: n_out.satisfied = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_na <= w_na;
            r_nb <= w_nb;
        end
        if (w_en2) r_ord <= w_ord;
        if (w_en3) r_out <= n_out;
    end

    assign o_valid = r_v3;
    assign o_data  = r_out;
endmodule

[rtl/mnpc_checker.sv]
// Port-level checker for the compare block, bound to the top level.
module mnpc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input mnpc_pkg::t_out o_data
);
    import mnpc_pkg::*;

    a_unord_unsat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.status && o_data.satisfied))
        else $error("unordered result marked satisfied");

    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> ##2 (o_valid || $past(i_stall)
            || $past(i_stall, 2) || $past(i_stall, 3)))
        else $error("transaction lost in pipeline");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");
endmodule

bind mixed_numeric_predicate_compare mnpc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);

[tb/mixed_numeric_predicate_compare_tb.sv]
// Testbench for the mixed numeric predicate compare block: directed and random checks.
`timescale 1ns / 100ps

module mixed_numeric_predicate_compare_tb;
    import mnpc_pkg::*;

    typedef enum logic [1:0] {ORD_LT, ORD_EQ, ORD_GT, ORD_UN} t_order;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [63:0] i_cfg_data;

    t_rel        cur_rel;
    t_kind       cur_kind;
    logic [63:0] cur_value;
    t_out        pending_results[$];
    int unsigned error_count;
    int unsigned item_count;
    int unsigned result_count;
    int unsigned unordered_count;
    int unsigned cycle_count;
    bit          jitter_on;

    mixed_numeric_predicate_compare u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Map an operand to floor (clamped to +-2^65) plus a fraction flag.
    function automatic void to_floor(input t_kind k, input logic [63:0] v,
                                     output logic nonfin, output logic signed [67:0] key,
                                     output logic frac);
        logic [65:0] mant;
        logic [65:0] mag;
        int          scale;
        int          sh;
        nonfin = 1'b0;
        frac   = 1'b0;
        if (!k[1]) begin
            if (k == KIND_UINT) key = {4'b0, v};
            else key = {{4{v[63]}}, v};
        end else begin
            nonfin = (v[62:52] == 11'h7FF);
            mant   = {13'b0, (v[62:52] != 0), v[51:0]};
            scale  = (v[62:52] == 0) ? 1 : int'(v[62:52]);
            if (scale >= 1075) begin
                sh  = scale - 1075;
                mag = (sh > 12) ? (66'd1 << 65) : (mant << sh);
            end else begin
                sh   = 1075 - scale;
                mag  = mant >> sh;
                frac = ((mag << sh) != mant);
            end
            key = {2'b0, mag};
            if (v[63]) key = -key - frac;
        end
    endfunction

    function automatic t_out predict_compare(input t_kind ak, input logic [63:0] av);
        t_out        r;
        t_order      o;
        logic        nfa, nfb, fa, fb;
        logic signed [67:0] ka, kb;
        logic [63:0] oa, ob;
        t_kind       ek;
        ek = cur_kind;
        to_floor(ak, av, nfa, ka, fa);
        to_floor(ek, cur_value, nfb, kb, fb);
        if (nfa || nfb) begin
            o = ORD_UN;
        end else if (ak[1] && ek[1]) begin
            // order floats on their bit patterns, both zeros folded together
            oa = (av[62:0] == 0) ? SIGN_BIT : (av[63] ? ~av : (av | SIGN_BIT));
            ob = (cur_value[62:0] == 0) ? SIGN_BIT :
                 (cur_value[63] ? ~cur_value : (cur_value | SIGN_BIT));
            o = (oa < ob) ? ORD_LT : ((oa > ob) ? ORD_GT : ORD_EQ);
        end else if (ka != kb) begin
            o = (ka < kb) ? ORD_LT : ORD_GT;
        end else begin
            o = (fa == fb) ? ORD_EQ : (fa ? ORD_GT : ORD_LT);
        end
        r.status    = (o == ORD_UN);
        r.satisfied = 1'b0;
        if (o != ORD_UN) begin
            case (cur_rel)
                REL_EQ: r.satisfied = (o == ORD_EQ);
                REL_NE: r.satisfied = (o != ORD_EQ);
                REL_LT: r.satisfied = (o == ORD_LT);
                REL_LE: r.satisfied = (o != ORD_GT);
                REL_GT: r.satisfied = (o == ORD_GT);
                REL_GE: r.satisfied = (o != ORD_LT);
                default: r.satisfied = 1'b0;
            endcase
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout, %0d results outstanding", $time, pending_results.size());
            $display("FAIL mixed_numeric_predicate_compare");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= jitter_on && ($urandom_range(99) < 9);
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: actual %b", $time, o_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                result_count++;
                if (o_data.satisfied !== want.satisfied) begin
                    $display("%0t satisfied mismatch: expected %b actual %b",
                             $time, want.satisfied, o_data.satisfied);
                    error_count++;
                end
                if (o_data.status !== want.status) begin
                    $display("%0t status mismatch: expected %b actual %b",
                             $time, want.status, o_data.status);
                    error_count++;
                end
            end
        end
    end

    task automatic send_compare(input t_kind k, input logic [63:0] v);
        if (jitter_on && ($urandom_range(99) < 5)) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        i_valid             <= 1'b1;
        i_data.actual_kind  <= k;
        i_data.actual_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(predict_compare(k, v));
        if (predict_compare(k, v).status) unordered_count++;
        item_count++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold until the pipe has drained.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (addr)
            CFG_RELATION: cur_rel = t_rel'(data[2:0]);
            CFG_EXP_KIND: cur_kind = t_kind'(data[1:0]);
            default:      cur_value = data;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(input t_rel r, input t_kind k, input logic [63:0] v);
        wait_drained();
        write_reg(CFG_RELATION, {61'b0, r});
        write_reg(CFG_EXP_KIND, {62'b0, k});
        write_reg(CFG_EXP_VAL, v);
    endtask

    function automatic logic [63:0] pick_value(input t_kind k);
        int n;
        n = $signed($urandom_range(40)) - 20;
        case ($urandom_range(7))
            0: return {$urandom, $urandom};
            1: return cur_value;
            2: return cur_value + 64'($signed($urandom_range(4)) - 2);
            3: return k[1] ? $realtobits(real'(n) + 0.5 * $urandom_range(1)) : 64'(n);
            4: return k[1] ? $realtobits(real'(cur_value) * ($urandom_range(1) ? 1.0 : -1.0))
                           : 64'($realtobits(-0.0));
            5: case ($urandom_range(5))
                   0: return SIGN_BIT;
                   1: return ~SIGN_BIT;
                   2: return '1;
                   3: return 64'h43E0_0000_0000_0000;   // 2^63
                   4: return 64'h43F0_0000_0000_0000;   // 2^64
                   default: return 64'hC3E0_0000_0000_0000;  // -2^63
               endcase
            6: return {1'($urandom_range(1)), 11'h7FF, 20'($urandom), $urandom};
            default: return {1'($urandom_range(1)), 11'($urandom_range(1023, 1100)),
                             20'($urandom), $urandom};
        endcase
    endfunction

    task automatic test_directed();
        set_config(REL_EQ, KIND_SINT, 64'd0);
        send_compare(KIND_SINT, 64'd0);
        send_compare(KIND_FLOAT, 64'h8000_0000_0000_0000);   // negative zero
        send_compare(KIND_FLOAT, 64'h0);
        send_compare(KIND_UINT, '1);
        send_compare(KIND_SINT, SIGN_BIT);
        send_compare(KIND_SINT, ~SIGN_BIT);
        send_compare(KIND_FLOAT, 64'h7FF0_0000_0000_0000);   // +inf
        send_compare(KIND_FLOAT, 64'hFFF0_0000_0000_0000);   // -inf
        send_compare(KIND_FLOAT, 64'h7FF8_0000_0000_0001);   // NaN
        send_compare(KIND_ALT, 64'h3FE0_0000_0000_0000);     // 0.5, alternate float code
        send_compare(KIND_FLOAT, 64'hBFE0_0000_0000_0000);   // -0.5
        send_compare(KIND_FLOAT, 64'h0000_0000_0000_0001);   // smallest subnormal
        set_config(REL_NE, KIND_FLOAT, 64'h7FF0_0000_0000_0000);
        send_compare(KIND_SINT, 64'd5);
        send_compare(KIND_FLOAT, 64'h7FF0_0000_0000_0000);
        set_config(REL_LT, KIND_UINT, '1);
        send_compare(KIND_FLOAT, 64'h43F0_0000_0000_0000);
        send_compare(KIND_UINT, 64'hFFFF_FFFF_FFFF_FFFE);
        set_config(REL_LE, KIND_SINT, SIGN_BIT);
        send_compare(KIND_FLOAT, 64'hC3E0_0000_0000_0000);
        send_compare(KIND_UINT, 64'd0);
        set_config(REL_GT, KIND_ALT, 64'h43E0_0000_0000_0000);
        send_compare(KIND_SINT, ~SIGN_BIT);
        send_compare(KIND_UINT, SIGN_BIT);
        set_config(REL_GE, KIND_FLOAT, 64'h8000_0000_0000_0000);
        send_compare(KIND_SINT, 64'd0);
        send_compare(KIND_SINT, '1);
        set_config(REL_X6, KIND_SINT, 64'd1);
        send_compare(KIND_SINT, 64'd1);
        set_config(REL_X7, KIND_UINT, 64'd1);
        send_compare(KIND_FLOAT, 64'h7FF0_0000_0000_0000);
    endtask

    task automatic test_random();
        t_kind k;
        for (int phase = 0; phase < 18; phase++) begin
            k = t_kind'($urandom_range(3));
            set_config(t_rel'($urandom_range(7)), k, pick_value(k));
            jitter_on = (phase != 4);
            for (int i = 0; i < 100; i++) begin
                k = t_kind'($urandom_range(3));
                send_compare(k, pick_value(k));
            end
        end
        jitter_on = 1'b1;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_stall     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = CFG_RELATION;
        i_cfg_data  = '0;
        cur_rel     = REL_EQ;
        cur_kind    = KIND_SINT;
        cur_value   = '0;
        error_count = 0;
        item_count  = 0;
        result_count = 0;
        unordered_count = 0;
        cycle_count = 0;
        jitter_on   = 1'b1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random();
        wait_drained();
        $display("Compared %0d transactions (%0d results, %0d unordered) over all kinds,",
                 item_count, result_count, unordered_count);
        $display("all relation codes and boundary, zero and non-finite operands.");
        if (error_count == 0) begin
            $display("PASS mixed_numeric_predicate_compare");
        end else begin
            $display("FAIL mixed_numeric_predicate_compare");
        end
        $finish;
    end

endmodule
